>>> sv/hacfp_pkg.sv
`default_nettype none

package hacfp_pkg;

  // Field widths
  localparam int CH_W      = 8;
  localparam int BYTE_W    = 8;
  localparam int MASK_W    = 64;
  localparam int CFG_IDX_W = 8;
  localparam int NUM_MASKS = 4;

  // Default payload store depth (valid range 1..64)
  localparam int PAYLOAD_DEPTH_DEF = 64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_1 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_2 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_3 = 8'd3;

  // Characters of the frame syntax
  localparam logic [CH_W-1:0] CHAR_START = 8'h3C;  // '<'
  localparam logic [CH_W-1:0] CHAR_0     = 8'h30;  // '0'
  localparam logic [CH_W-1:0] CHAR_9     = 8'h39;  // '9'
  localparam logic [CH_W-1:0] CHAR_UA    = 8'h41;  // 'A'
  localparam logic [CH_W-1:0] CHAR_UF    = 8'h46;  // 'F'
  localparam logic [CH_W-1:0] CHAR_LA    = 8'h61;  // 'a'
  localparam logic [CH_W-1:0] CHAR_LF    = 8'h66;  // 'f'
  localparam logic [3:0]      NIB_TEN    = 4'd10;

  // Hex digit to nibble; anything else decodes as zero
  function automatic logic [3:0] hex_nibble(input logic [CH_W-1:0] c);
    logic [3:0] nib;
    nib = 4'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      nib = c[3:0];
    end else if (c >= CHAR_UA && c <= CHAR_UF) begin
      nib = 4'(c - CHAR_UA) + NIB_TEN;
    end else if (c >= CHAR_LA && c <= CHAR_LF) begin
      nib = 4'(c - CHAR_LA) + NIB_TEN;
    end
    return nib;
  endfunction

endpackage

`default_nettype wire

>>> sv/hacfp_if.sv
`default_nettype none

// Character input channel
interface hacfp_in_if import hacfp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch_in;

  modport source (output valid, output ch_in, input ready);
  modport sink (input valid, input ch_in, output ready);
endinterface

// Result channel
interface hacfp_out_if import hacfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_command;
  logic [BYTE_W-1:0] frame_length;
  logic [BYTE_W-1:0] data_byte;
  logic              data_valid;
  logic [BYTE_W-1:0] rx_checksum;
  logic              truncated;
  logic              last;

  modport source (output valid, output frame_command, output frame_length,
                  output data_byte, output data_valid, output rx_checksum,
                  output truncated, output last, input ready);
  modport sink (input valid, input frame_command, input frame_length,
                input data_byte, input data_valid, input rx_checksum,
                input truncated, input last, output ready);
endinterface

// Configuration write channel
interface hacfp_cfg_if import hacfp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [MASK_W-1:0]    wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

>>> sv/hex_ascii_command_frame_parser_top.sv
`default_nettype none

// Channel  | Dir | Payload                                         | Transaction
// ---------+-----+-------------------------------------------------+-------------------
// in_ch    | in  | ch_in                                           | valid & ready
// out_res  | out | frame_command, frame_length, data_byte,         | valid & ready
//          |     | data_valid, rx_checksum, truncated, last        |
// cfg_wr   | in  | reg_index, wr_data (handler masks 0..3)         | valid & ready
//
// Parsing takes one character per cycle while input is not held off. A dispatched
// frame holds off input while its payload is read back from the single-port store,
// one result per cycle when the sink is ready, with at most PAYLOAD_DEPTH results.
// The output register lets input resume while the final result waits.
// Synchronous active-low reset; no clearing pass, store contents are don't-care.
// Configuration is always ready.

module hex_ascii_command_frame_parser_top
  import hacfp_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  wire            clk,
  input  wire            rst_n,
  hacfp_in_if.sink       in_ch,
  hacfp_out_if.source    out_res,
  hacfp_cfg_if.sink      cfg_wr
);

  localparam int AW    = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int CNT_W = $clog2(PAYLOAD_DEPTH + 1);
  localparam logic [BYTE_W-1:0] DEPTH_B = BYTE_W'(PAYLOAD_DEPTH);
  localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(PAYLOAD_DEPTH);

  // Parser phases
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_CMD_H = 4'd1;
  localparam logic [3:0] PH_CMD_L = 4'd2;
  localparam logic [3:0] PH_LEN_H = 4'd3;
  localparam logic [3:0] PH_LEN_L = 4'd4;
  localparam logic [3:0] PH_PAY_H = 4'd5;
  localparam logic [3:0] PH_PAY_L = 4'd6;
  localparam logic [3:0] PH_CHK_H = 4'd7;
  localparam logic [3:0] PH_CHK_L = 4'd8;
  localparam logic [3:0] PH_TERM  = 4'd9;

  // Control and frame state
  logic [3:0]        phase_r, phase_nxt;
  logic [BYTE_W-1:0] cmd_r, cmd_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;
  logic [BYTE_W-1:0] cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] part_r, part_nxt;
  logic [BYTE_W-1:0] chk_r, chk_nxt;
  logic [MASK_W-1:0] mask_r [NUM_MASKS];

  // Read-back control
  logic              emit_r, emit_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;

  // Payload store
  logic [BYTE_W-1:0] store [PAYLOAD_DEPTH];
  logic [BYTE_W-1:0] mem_q_r;
  logic              mem_we, mem_re;
  logic [BYTE_W-1:0] mem_wdata;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] o_cmd_r, o_len_r, o_data_r, o_chk_r;
  logic              o_dv_r, o_trunc_r, o_last_r;

  logic              in_acc;
  logic [3:0]        nib;
  logic [BYTE_W-1:0] byte_full;
  logic [BYTE_W-1:0] cnt_inc;
  logic [MASK_W-1:0] sel_mask;
  logic              disp;
  logic              trunc;
  logic [CNT_W-1:0]  n_items;
  logic              out_free, rd_more, empty_go, load_data, out_load, load_last;

  assign in_ch.ready  = !emit_r;
  assign cfg_wr.ready = 1'b1;
  assign in_acc       = in_ch.valid && !emit_r;

  assign nib       = hex_nibble(in_ch.ch_in);
  assign byte_full = {part_r[7:4], nib};
  assign cnt_inc   = cnt_r + 8'd1;

  // Dispatch check against the handler masks
  assign sel_mask = mask_r[cmd_r[7:6]];
  assign disp     = sel_mask[cmd_r[5:0]];

  assign trunc   = (len_r > DEPTH_B);
  assign n_items = trunc ? DEPTH_C : len_r[CNT_W-1:0];

  // Read-back handshake: one read in flight, output register as the sink
  assign out_free  = !out_valid_r || out_res.ready;
  assign rd_more   = emit_r && (rd_idx_r != n_items);
  assign empty_go  = emit_r && (n_items == '0) && out_free;
  assign mem_re    = rd_more && (!rd_pend_r || out_free);
  assign load_data = rd_pend_r && out_free;
  assign out_load  = load_data || empty_go;
  assign load_last = (rd_idx_r == n_items);

  // Store write on the low payload digit
  assign mem_we    = in_acc && (in_ch.ch_in != CHAR_START) && (phase_r == PH_PAY_L)
                     && (cnt_r < DEPTH_B);
  assign mem_wdata = byte_full;

  // Parser next state
  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    part_nxt  = part_r;
    chk_nxt   = chk_r;
    emit_nxt  = emit_r;
    rd_idx_nxt = rd_idx_r;
    if (in_acc) begin
      if (in_ch.ch_in == CHAR_START) begin
        phase_nxt = PH_CMD_H;
        cnt_nxt   = '0;
      end else begin
        case (phase_r)
          PH_CMD_H: begin
            cmd_nxt   = {nib, 4'd0};
            phase_nxt = PH_CMD_L;
          end
          PH_CMD_L: begin
            cmd_nxt   = {cmd_r[7:4], nib};
            phase_nxt = PH_LEN_H;
          end
          PH_LEN_H: begin
            len_nxt   = {nib, 4'd0};
            phase_nxt = PH_LEN_L;
          end
          PH_LEN_L: begin
            len_nxt   = {len_r[7:4], nib};
            phase_nxt = ({len_r[7:4], nib} != '0) ? PH_PAY_H : PH_CHK_H;
          end
          PH_PAY_H: begin
            part_nxt  = {nib, 4'd0};
            phase_nxt = PH_PAY_L;
          end
          PH_PAY_L: begin
            part_nxt  = byte_full;
            cnt_nxt   = cnt_inc;
            phase_nxt = (cnt_inc < len_r) ? PH_PAY_H : PH_CHK_H;
          end
          PH_CHK_H: begin
            chk_nxt   = {nib, 4'd0};
            phase_nxt = PH_CHK_L;
          end
          PH_CHK_L: begin
            chk_nxt   = {chk_r[7:4], nib};
            phase_nxt = PH_TERM;
          end
          PH_TERM: begin
            phase_nxt = PH_IDLE;
            if (disp) begin
              emit_nxt   = 1'b1;
              rd_idx_nxt = '0;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
    // Read-back progress
    if (mem_re) begin
      rd_idx_nxt = rd_idx_r + 1'b1;
    end
    if ((load_data && load_last) || empty_go) begin
      emit_nxt = 1'b0;
    end
  end

  always_comb begin
    rd_pend_nxt = rd_pend_r;
    if (mem_re) begin
      rd_pend_nxt = 1'b1;
    end else if (load_data) begin
      rd_pend_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cmd_r       <= '0;
      len_r       <= '0;
      cnt_r       <= '0;
      part_r      <= '0;
      chk_r       <= '0;
      emit_r      <= 1'b0;
      rd_pend_r   <= 1'b0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cmd_r       <= cmd_nxt;
      len_r       <= len_nxt;
      cnt_r       <= cnt_nxt;
      part_r      <= part_nxt;
      chk_r       <= chk_nxt;
      emit_r      <= emit_nxt;
      rd_pend_r   <= rd_pend_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Handler mask registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_MASKS; i++) begin
        mask_r[i] <= '0;
      end
    end else if (cfg_wr.valid) begin
      case (cfg_wr.reg_index)
        CFG_MASK_0: mask_r[0] <= cfg_wr.wr_data;
        CFG_MASK_1: mask_r[1] <= cfg_wr.wr_data;
        CFG_MASK_2: mask_r[2] <= cfg_wr.wr_data;
        CFG_MASK_3: mask_r[3] <= cfg_wr.wr_data;
        default: ;
      endcase
    end
  end

  // Payload store: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[cnt_r[AW-1:0]] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= store[rd_idx_r[AW-1:0]];
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_cmd_r   <= cmd_r;
      o_len_r   <= len_r;
      o_chk_r   <= chk_r;
      o_trunc_r <= trunc;
      o_data_r  <= load_data ? mem_q_r : '0;
      o_dv_r    <= load_data;
      o_last_r  <= load_data ? load_last : 1'b1;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.frame_command = o_cmd_r;
  assign out_res.frame_length  = o_len_r;
  assign out_res.data_byte     = o_data_r;
  assign out_res.data_valid    = o_dv_r;
  assign out_res.rx_checksum   = o_chk_r;
  assign out_res.truncated     = o_trunc_r;
  assign out_res.last          = o_last_r;

endmodule

`default_nettype wire
